### rtl/ker_pkg.sv
`timescale 1ns / 1ps

package ker_pkg;

  // field widths on the ports
  localparam int VEL_FIELD_W  = 24;
  localparam int MASS_FIELD_W = 16;
  localparam int SUM_W        = 63;
  localparam int MAX_SPEED_W  = 24;

  // bits of each field that take part in the arithmetic
  localparam int VELOCITY_BITS = 24;
  localparam int MASS_BITS     = 16;

  // squared speed: three squares of magnitudes up to 2^(VELOCITY_BITS-1)
  localparam int V2_W  = 2 * VELOCITY_BITS;
  // floor(mass * v2 / 2)
  localparam int E_W   = MASS_BITS + V2_W - 1;
  // square root datapath
  localparam int ROOT_W = VELOCITY_BITS;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } ker_sqrt_stat_t;

endpackage

### rtl/ker_lane.sv
`timescale 1ns / 1ps

// one velocity component: magnitude, then its square, registered
module ker_lane
  import ker_pkg::*;
(
  input  logic                   clk,
  input  logic [VEL_FIELD_W-1:0] vel,
  output logic [V2_W-1:0]        sq
);

  logic [VELOCITY_BITS-1:0] v;
  logic [VELOCITY_BITS-1:0] mag;
  logic [V2_W-1:0]          sq_nxt;
  logic [V2_W-1:0]          sq_r;

  always_comb begin
    v      = vel[VELOCITY_BITS-1:0];
    mag    = v[VELOCITY_BITS-1] ? (~v + 1'b1) : v;
    sq_nxt = V2_W'(mag) * V2_W'(mag);
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

### rtl/ker_merge.sv
`timescale 1ns / 1ps

// joins the three lanes: sum of squares, then times mass over two
module ker_merge
  import ker_pkg::*;
(
  input  logic                 clk,
  input  logic [V2_W-1:0]      sq_x,
  input  logic [V2_W-1:0]      sq_y,
  input  logic [V2_W-1:0]      sq_z,
  input  logic [MASS_BITS-1:0] mass,
  output logic [V2_W-1:0]      v2,
  output logic [E_W-1:0]       energy
);

  logic [V2_W-1:0]           v2a_r;
  logic [MASS_BITS-1:0]      massa_r;
  logic [V2_W-1:0]           v2b_r;
  logic [E_W-1:0]            energy_r;
  logic [MASS_BITS+V2_W-1:0] prod;

  assign prod = (MASS_BITS + V2_W)'(massa_r) * (MASS_BITS + V2_W)'(v2a_r);

  always_ff @(posedge clk) begin
    v2a_r    <= sq_x + sq_y + sq_z;
    massa_r  <= mass;
    v2b_r    <= v2a_r;
    energy_r <= prod[MASS_BITS+V2_W-1:1];
  end

  assign v2     = v2b_r;
  assign energy = energy_r;

endmodule

### rtl/ker_isqrt.sv
`timescale 1ns / 1ps

// floor square root, one root bit per cycle; result held until ack
module ker_isqrt
  import ker_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [V2_W-1:0]   radicand,
  input  logic              ack,
  output ker_sqrt_stat_t    stat,
  output logic [ROOT_W-1:0] root
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [REM_W-1:0]   rem_r;
  logic [V2_W-1:0]    rad_r;
  logic [ROOT_W-1:0]  root_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               fits;

  always_comb begin
    rem_sh = {rem_r, rad_r[V2_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_r, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            rad_r   <= radicand;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNT_W'(ROOT_W - 1);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rad_r <= {rad_r[V2_W-3:0], 2'b00};
          if (fits) begin
            rem_r  <= REM_W'(rem_sh - trial);
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[REM_W-1:0];
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (ack) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign root      = root_r;

endmodule

### rtl/kinetic_energy_reduce.sv
`timescale 1ns / 1ps
// Throughput: one word a cycle inside a set; after a word marked last, in_ready stays
// low until the result is in the output register, as set by the 24-step bit-serial
// square root that runs once per set.
// Reset (rst_n, synchronous, active low) empties the pipeline, clears the energy sum,
// the peak squared speed and the overflow flag, and drops out_valid.

module kinetic_energy_reduce
  import ker_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VEL_FIELD_W-1:0]  in_vel_x,
  input  logic [VEL_FIELD_W-1:0]  in_vel_y,
  input  logic [VEL_FIELD_W-1:0]  in_vel_z,
  input  logic [MASS_FIELD_W-1:0] in_atom_mass,
  input  logic                    in_last_atom,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SUM_W-1:0]        out_kinetic_energy,
  output logic [MAX_SPEED_W-1:0]  out_max_speed,
  output logic                    out_energy_overflow
);

  logic accept;

  // pipeline control: stage 1 lanes, stage 2 sum of squares, stage 3 energy
  logic                 vld1_r, vld2_r, vld3_r;
  logic                 last1_r, last2_r, last3_r;
  logic [MASS_BITS-1:0] mass1_r;

  // a set-closing word is in flight until its result reaches the output register
  logic hold_r;

  logic [V2_W-1:0] sq_x, sq_y, sq_z;
  logic [V2_W-1:0] v2;
  logic [E_W-1:0]  energy;

  // running state of the current set
  logic [SUM_W-1:0] sum_r;
  logic [V2_W-1:0]  max_r;
  logic             sat_r;

  logic [SUM_W-1:0] e_ext;
  logic             would_sat;
  logic [SUM_W-1:0] sum_nxt;
  logic [V2_W-1:0]  max_nxt;
  logic             sat_nxt;

  // totals of a finished set, waiting on the root
  logic [SUM_W-1:0] fin_sum_r;
  logic             fin_sat_r;
  logic             sqrt_start;

  ker_sqrt_stat_t    sq_stat;
  logic [ROOT_W-1:0] root;
  logic              load_out;

  logic                   out_valid_r;
  logic [SUM_W-1:0]       out_energy_r;
  logic [MAX_SPEED_W-1:0] out_speed_r;
  logic                   out_ovf_r;

  assign in_ready = !hold_r;
  assign accept   = in_valid && in_ready;

  // three velocity lanes in parallel
  ker_lane u_lane_x (.clk(clk), .vel(in_vel_x), .sq(sq_x));
  ker_lane u_lane_y (.clk(clk), .vel(in_vel_y), .sq(sq_y));
  ker_lane u_lane_z (.clk(clk), .vel(in_vel_z), .sq(sq_z));

  ker_merge u_merge (
    .clk    (clk),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .sq_z   (sq_z),
    .mass   (mass1_r),
    .v2     (v2),
    .energy (energy)
  );

  // accumulate: keep the peak v2 and add the atom's energy with saturation
  always_comb begin
    e_ext     = SUM_W'(energy);
    would_sat = e_ext > (SUM_MAX - sum_r);
    sum_nxt   = would_sat ? SUM_MAX : (sum_r + e_ext);
    sat_nxt   = sat_r || would_sat;
    max_nxt   = (v2 > max_r) ? v2 : max_r;
  end

  assign sqrt_start = vld3_r && last3_r;

  ker_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (max_nxt),
    .ack      (load_out),
    .stat     (sq_stat),
    .root     (root)
  );

  // the root waits in the unit while an older result still sits at the output
  assign load_out = sq_stat.done && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      hold_r      <= 1'b0;
      sum_r       <= '0;
      max_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r <= accept;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;

      if (accept && in_last_atom) begin
        hold_r <= 1'b1;
      end else if (load_out) begin
        hold_r <= 1'b0;
      end

      if (vld3_r) begin
        if (last3_r) begin
          // set ends: hand totals on, start afresh
          sum_r <= '0;
          max_r <= '0;
          sat_r <= 1'b0;
        end else begin
          sum_r <= sum_nxt;
          max_r <= max_nxt;
          sat_r <= sat_nxt;
        end
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last1_r <= in_last_atom;
    mass1_r <= in_atom_mass[MASS_BITS-1:0];
    last2_r <= last1_r;
    last3_r <= last2_r;
    if (sqrt_start) begin
      fin_sum_r <= sum_nxt;
      fin_sat_r <= sat_nxt;
    end
    if (load_out) begin
      out_energy_r <= fin_sum_r;
      out_speed_r  <= MAX_SPEED_W'(root);
      out_ovf_r    <= fin_sat_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kinetic_energy  = out_energy_r;
  assign out_max_speed       = out_speed_r;
  assign out_energy_overflow = out_ovf_r;

endmodule
